FILE: hdl/online_covariance_update_assert.svh
// Assertion macros for the online covariance update RTL.
// Needs i_clk and i_rst_n in the scope where they are used.
`ifndef ONLINE_COVARIANCE_UPDATE_ASSERT_SVH
`define ONLINE_COVARIANCE_UPDATE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define OCU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("online_covariance_update: assertion failed");

// Next-cycle implication, checked out of reset.
`define OCU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("online_covariance_update: assertion failed");

`endif

FILE: hdl/ocu_pkg.sv
// Shared constants, types and helpers for the online covariance update block.
// No dependencies.
package ocu_pkg;

    localparam int N_DIMS    = 8;
    localparam int FRAC_BITS = 16;

    localparam int VAL_W  = 32;            // Q16.16 sample / mean
    localparam int IDX_W  = 3;
    localparam int CNT_W  = 32;            // sample count
    localparam int COV_W  = 48;            // Q32.16 covariance
    localparam int ST_W   = 2;
    localparam int DX_W   = VAL_W + 1;
    localparam int MAG_W  = VAL_W;         // |dx| < 2^32
    localparam int PROD_W = 2 * MAG_W;
    localparam int PMAG_W = PROD_W - FRAC_BITS;
    localparam int DIV_W  = ((PMAG_W > COV_W - 1) ? PMAG_W : COV_W - 1) + 1;
    localparam int NC_W   = DIV_W + 2;
    localparam int TRI_SIZE = N_DIMS * (N_DIMS + 1) / 2;
    localparam int POS_W  = $clog2(TRI_SIZE);

    localparam int IN_FIELDS_W  = VAL_W + IDX_W + CNT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = IDX_W + IDX_W + COV_W + VAL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_SAT  = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic load;
        logic dx_start;
        logic mean_upd;
        logic rd;
        logic p_start;
        logic c_start;
        logic c_fin;
        logic emit;
        logic emit_zero;
    } t_dp_cmd;

    typedef struct packed {
        logic in_zero;
        logic in_bad;
        logic div_done;
        logic out_free;
        logic last_k;
    } t_dp_status;

    // Start of row i in the packed lower triangle.
    function automatic logic [POS_W-1:0] tri_base(input logic [IDX_W-1:0] idx);
        logic [POS_W+1:0] prod;
        prod = (POS_W+2)'(idx) * ((POS_W+2)'(idx) + (POS_W+2)'(1));
        return prod[POS_W:1];
    endfunction

endpackage

FILE: hdl/ocu_div.sv
// Shared restoring divider, one quotient bit per cycle (unsigned).
// Depends on ocu_pkg.
module ocu_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ocu_pkg::DIV_W-1:0]  i_dividend,
    input  logic [ocu_pkg::CNT_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [ocu_pkg::DIV_W-1:0]  o_quot
);
    import ocu_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  r_quot, n_quot;
    logic [CNT_W:0]    r_rem, n_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W:0]    shifted;
    logic [CNT_W+1:0]  trial;

    always_comb begin
        shifted = {r_rem[CNT_W-1:0], r_quot[DIV_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_dvs};
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_step  = r_step;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_step = STEP_W'(DIV_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = trial[CNT_W+1] ? shifted : trial[CNT_W:0];
            n_quot = {r_quot[DIV_W-2:0], ~trial[CNT_W+1]};
            n_step = r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: hdl/ocu_datapath.sv
// Datapath: stores, multiplier, shared divider and output register.
// Depends on ocu_pkg and ocu_div.
module ocu_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ocu_pkg::t_dp_cmd                i_cmd,
    output ocu_pkg::t_dp_status             o_status,
    input  logic [ocu_pkg::IN_TDATA_W-1:0]  i_in_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [ocu_pkg::OUT_TDATA_W-1:0] o_out_data,
    output logic                            o_out_last,
    output logic [ocu_pkg::ST_W-1:0]        o_out_status
);
    import ocu_pkg::*;

    // input fields
    logic signed [VAL_W-1:0] in_x;
    logic [IDX_W-1:0]        in_idx;
    logic [CNT_W-1:0]        in_m;

    assign in_x   = i_in_data[VAL_W-1:0];
    assign in_idx = i_in_data[VAL_W+IDX_W-1:VAL_W];
    assign in_m   = i_in_data[VAL_W+IDX_W+CNT_W-1:VAL_W+IDX_W];

    // stores
    logic signed [VAL_W-1:0] r_mean [N_DIMS];
    logic signed [DX_W-1:0]  r_delta [N_DIMS];
    logic signed [COV_W-1:0] cov_mem [TRI_SIZE];
    logic [TRI_SIZE-1:0]     r_cov_vld;

    // working registers
    logic signed [VAL_W-1:0] r_x;
    logic [IDX_W-1:0]        r_idx, r_k;
    logic [CNT_W-1:0]        r_m;
    logic signed [DX_W-1:0]  r_dx;
    logic signed [VAL_W-1:0] r_mean_new;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_prod_neg;
    logic [PMAG_W-1:0]       r_p_mag;
    logic                    r_p_neg;
    logic signed [COV_W-1:0] r_c_raw, r_c;
    logic                    r_c_hit;
    logic                    r_diff_neg;
    logic signed [COV_W-1:0] r_nc;
    logic                    r_sat;

    // output register
    logic                    r_ov;
    logic [IDX_W-1:0]        r_o_row, r_o_col;
    logic signed [COV_W-1:0] r_o_cov;
    logic signed [VAL_W-1:0] r_o_mean;
    logic                    r_o_last;
    logic [ST_W-1:0]         r_o_st;

    // divider
    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_arg, div_q;

    ocu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_arg),
        .i_divisor  (r_m),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // combinational helpers
    logic [POS_W-1:0]         pos;
    logic signed [DX_W-1:0]   dx_new, dk;
    logic [DX_W-1:0]          dx_new_neg, r_dx_abs, dk_abs;
    logic [PROD_W-1:0]        prod_rnd;
    logic [PMAG_W-1:0]        v_mag;
    logic signed [PMAG_W:0]   val;
    logic signed [COV_W-1:0]  c_now;
    logic signed [DIV_W:0]    diff;
    logic [DIV_W:0]           diff_abs;
    logic signed [VAL_W+1:0]  mean_sum;
    logic signed [NC_W-1:0]   nc_wide, q_signed;
    logic                     out_free;

    localparam logic signed [NC_W-1:0] COV_MAX = NC_W'({1'b0, {(COV_W-1){1'b1}}});
    localparam logic signed [NC_W-1:0] COV_MIN = -COV_MAX - NC_W'(1);

    always_comb begin
        pos        = tri_base(r_idx) + POS_W'(r_k);
        dx_new     = DX_W'(r_x) - DX_W'(r_mean[r_idx]);
        dx_new_neg = -dx_new;
        r_dx_abs   = r_dx[DX_W-1] ? -r_dx : r_dx;
        dk         = r_delta[r_k];
        dk_abs     = dk[DX_W-1] ? -dk : dk;
        prod_rnd   = r_prod + PROD_W'(1 << (FRAC_BITS - 1));
        v_mag      = r_p_mag - div_q[PMAG_W-1:0];
        val        = r_p_neg ? -$signed({1'b0, v_mag}) : $signed({1'b0, v_mag});
        c_now      = r_c_hit ? r_c_raw : '0;
        diff       = (DIV_W+1)'(val) - (DIV_W+1)'(c_now);
        diff_abs   = diff[DIV_W] ? -diff : diff;
        mean_sum   = (VAL_W+2)'(r_mean[r_idx])
                   + (r_dx[DX_W-1] ? -$signed({1'b0, div_q[DX_W-1:0]})
                                   :  $signed({1'b0, div_q[DX_W-1:0]}));
        q_signed   = r_diff_neg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
        nc_wide    = NC_W'(r_c) + q_signed;
        out_free   = !r_ov || i_out_ready;

        div_start = i_cmd.dx_start || i_cmd.p_start || i_cmd.c_start;
        if (i_cmd.dx_start) begin
            div_arg = DIV_W'(dx_new[DX_W-1] ? dx_new_neg : dx_new);
        end else if (i_cmd.p_start) begin
            div_arg = DIV_W'(prod_rnd[PROD_W-1:FRAC_BITS]);
        end else begin
            div_arg = diff_abs[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= in_x;
            r_idx <= in_idx;
            r_m   <= in_m;
            r_k   <= '0;
        end
        if (i_cmd.dx_start) begin
            r_dx           <= dx_new;
            r_delta[r_idx] <= dx_new;
        end
        if (i_cmd.rd) begin
            r_prod     <= r_dx_abs[MAG_W-1:0] * dk_abs[MAG_W-1:0];
            r_prod_neg <= r_dx[DX_W-1] ^ dk[DX_W-1];
            r_c_raw    <= cov_mem[pos];
            r_c_hit    <= r_cov_vld[pos];
        end
        if (i_cmd.p_start) begin
            r_p_mag <= prod_rnd[PROD_W-1:FRAC_BITS];
            r_p_neg <= r_prod_neg;
        end
        if (i_cmd.c_start) begin
            r_c        <= c_now;
            r_diff_neg <= diff[DIV_W];
        end
        if (i_cmd.c_fin) begin
            if (nc_wide > COV_MAX) begin
                r_nc  <= COV_MAX[COV_W-1:0];
                r_sat <= 1'b1;
            end else if (nc_wide < COV_MIN) begin
                r_nc  <= COV_MIN[COV_W-1:0];
                r_sat <= 1'b1;
            end else begin
                r_nc  <= nc_wide[COV_W-1:0];
                r_sat <= 1'b0;
            end
        end
        if (i_cmd.mean_upd) begin
            r_mean_new <= mean_sum[VAL_W-1:0];
        end
        if (i_cmd.emit) begin
            cov_mem[pos] <= r_nc;
            r_k          <= r_k + IDX_W'(1);
            r_o_row      <= r_idx;
            r_o_col      <= r_k;
            r_o_cov      <= r_nc;
            r_o_mean     <= r_mean_new;
            r_o_last     <= (r_k == r_idx);
            r_o_st       <= r_sat ? ST_SAT : ST_OK;
        end else if (i_cmd.emit_zero) begin
            r_o_row  <= r_idx;
            r_o_col  <= '0;
            r_o_cov  <= '0;
            r_o_mean <= '0;
            r_o_last <= 1'b1;
            r_o_st   <= ST_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov      <= 1'b0;
            r_cov_vld <= '0;
            for (int i = 0; i < N_DIMS; i++) begin
                r_mean[i] <= '0;
            end
        end else begin
            if (i_cmd.emit || i_cmd.emit_zero) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_cov_vld[pos] <= 1'b1;
            end
            if (i_cmd.mean_upd) begin
                r_mean[r_idx] <= mean_sum[VAL_W-1:0];
            end
        end
    end

    assign o_status.in_zero  = (in_m == '0);
    assign o_status.in_bad   = (32'(in_idx) >= 32'(N_DIMS));
    assign o_status.div_done = div_done;
    assign o_status.out_free = out_free;
    assign o_status.last_k   = (r_k == r_idx);

    assign o_out_valid  = r_ov;
    assign o_out_data   = OUT_TDATA_W'({r_o_mean, r_o_cov, r_o_col, r_o_row});
    assign o_out_last   = r_o_last;
    assign o_out_status = r_o_st;

endmodule

FILE: hdl/ocu_ctrl.sv
// Controller state machine sequencing the covariance update datapath.
// Depends on ocu_pkg.
module ocu_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ocu_pkg::t_dp_status  i_status,
    output ocu_pkg::t_dp_cmd     o_cmd,
    output logic                 o_busy
);
    import ocu_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DX   = 9'b000000010,
        S_MDIV = 9'b000000100,
        S_RD   = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_PDIV = 9'b000100000,
        S_CDIV = 9'b001000000,
        S_OUT  = 9'b010000000,
        S_ZERO = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.in_zero) begin
                        n_state = S_ZERO;
                    end else if (!i_status.in_bad) begin
                        n_state = S_DX;
                    end
                end
            end
            S_DX: begin
                o_cmd.dx_start = 1'b1;
                n_state        = S_MDIV;
            end
            S_MDIV: begin
                if (i_status.div_done) begin
                    o_cmd.mean_upd = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.p_start = 1'b1;
                n_state       = S_PDIV;
            end
            S_PDIV: begin
                if (i_status.div_done) begin
                    o_cmd.c_start = 1'b1;
                    n_state       = S_CDIV;
                end
            end
            S_CDIV: begin
                if (i_status.div_done) begin
                    o_cmd.c_fin = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.last_k ? S_IDLE : S_RD;
                end
            end
            S_ZERO: begin
                if (i_status.out_free) begin
                    o_cmd.emit_zero = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_busy     = (r_state != S_IDLE);

endmodule

FILE: hdl/online_covariance_update.sv
// Top level of the online mean / covariance update block.
// Depends on ocu_pkg, ocu_ctrl, ocu_datapath and online_covariance_update_assert.svh.
//
//  channel | dir | tdata (low bit up)                         | tlast           | tuser
//  s_axis  | in  | component_value, component_index,          | last_component  | -
//          |     | sample_count, zero fill (72 bits)          |                 |
//  m_axis  | out | row_index, col_index, cov_value,           | last_of_run     | status
//          |     | mean_value, zero fill (88 bits)            |                 |
//
// Per word with index i: the mean division, then for each column 0..i a read, multiply,
// product division, covariance division and emit (49-bit shared restoring divider, one
// bit a cycle, used twice per entry).
// A zero count word gives one result; no clearing pass after reset.
// Reset is synchronous, active low; a stalled m_axis holds only the last emit step.
`include "online_covariance_update_assert.svh"

module online_covariance_update (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // component_value[31:0], component_index[34:32], sample_count[66:35]
    input  logic [ocu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // row_index[2:0], col_index[5:3], cov_value[53:6], mean_value[85:54]
    output logic [ocu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    // status[1:0]
    output logic [ocu_pkg::ST_W-1:0]        m_axis_tuser
);
    import ocu_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       busy;
    logic       in_last_unused;

    // tlast on the input carries no meaning for the update
    assign in_last_unused = s_axis_tlast;

    ocu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    ocu_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_in_data    (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata),
        .o_out_last   (m_axis_tlast),
        .o_out_status (m_axis_tuser)
    );

    // input is only taken with the sequencer at rest
    `OCU_ASSERT_IMPL(a_ready_idle, s_axis_tready, !busy && !in_last_unused || !busy)
    // column never exceeds row on a result
    `OCU_ASSERT_IMPL(a_col_le_row, m_axis_tvalid, m_axis_tdata[5:3] <= m_axis_tdata[2:0])
    // final entry of a normal run sits on the diagonal
    `OCU_ASSERT_IMPL(a_last_diag, m_axis_tvalid && m_axis_tlast && m_axis_tuser != ST_ZERO,
        m_axis_tdata[5:3] == m_axis_tdata[2:0])
    // an emitted result is valid on the next cycle
    `OCU_ASSERT_NEXT(a_emit_shows, cmd.emit || cmd.emit_zero, m_axis_tvalid)

endmodule

FILE: bench/online_covariance_update_tb.sv
// Self-checking bench for online_covariance_update: directed table, then random sample vectors and stray words.
// Depends on ocu_pkg and the RTL of online_covariance_update.
module online_covariance_update_tb;
    import ocu_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int RAND_ITEMS = 160;
    localparam int HOLD_AT_WORD = 25;
    localparam int HOLD_CYCLES = 4000;
    localparam longint COV_MAX = (64'sd1 <<< (COV_W - 1)) - 1;
    localparam longint COV_MIN = -(64'sd1 <<< (COV_W - 1));

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [COV_W-1:0] cov;
        logic [VAL_W-1:0] mean;
        logic             last;
        logic [ST_W-1:0]  st;
    } t_cov_entry;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
        bit               last;
        bit               typed;   // single result given below instead of the predictor
        logic [VAL_W-1:0] t_mean;
        logic [ST_W-1:0]  t_st;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic [ST_W-1:0] m_axis_tuser;

    // predictor state
    longint mean_mdl[N_DIMS];
    longint cov_mdl[TRI_SIZE];
    longint delta_mdl[N_DIMS];

    t_cov_entry pending_entries[$];
    t_stim_row dir_tab[$];
    int errors = 0;
    int cycles = 0;
    bit feed_done = 0;

    online_covariance_update uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Welford step: push the expected covariance entries for one accepted word.
    task automatic predict_update(input t_stim_row w);
        longint x, m, dx, mnew, p, val, c, nc, other;
        logic [63:0] ma, mb, mag;
        bit neg;
        int pos;
        t_cov_entry e;
        if (w.cnt == 0) begin
            e = '{row: w.idx, col: '0, cov: '0, mean: '0, last: 1'b1, st: ST_ZERO};
            pending_entries.push_back(e);
        end else begin
            x = longint'($signed(w.value));
            m = longint'({32'b0, w.cnt});
            dx = x - mean_mdl[w.idx];
            delta_mdl[w.idx] = dx;
            mnew = mean_mdl[w.idx] + dx / m;
            mean_mdl[w.idx] = mnew;
            for (int k = 0; k <= w.idx; k++) begin
                pos = w.idx * (w.idx + 1) / 2 + k;
                other = delta_mdl[k];
                neg = (dx < 0) != (other < 0);
                ma = (dx < 0) ? 64'(-dx) : 64'(dx);
                mb = (other < 0) ? 64'(-other) : 64'(other);
                mag = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                p = neg ? -longint'(mag) : longint'(mag);
                val = p - p / m;
                c = cov_mdl[pos];
                nc = c + (val - c) / m;
                e.st = ST_OK;
                if (nc > COV_MAX) begin
                    nc = COV_MAX;
                    e.st = ST_SAT;
                end
                if (nc < COV_MIN) begin
                    nc = COV_MIN;
                    e.st = ST_SAT;
                end
                cov_mdl[pos] = nc;
                e.row = w.idx;
                e.col = IDX_W'(k);
                e.cov = nc[COV_W-1:0];
                e.mean = mnew[VAL_W-1:0];
                e.last = (k == w.idx);
                if (!w.typed)
                    pending_entries.push_back(e);
            end
        end
        if (w.typed && w.cnt != 0) begin
            e = '{row: w.idx, col: '0, cov: '0, mean: w.t_mean, last: 1'b1, st: w.t_st};
            pending_entries.push_back(e);
        end else if (w.typed) begin
            // zero count: predictor entry already pushed; swap for the typed one
            void'(pending_entries.pop_back());
            e = '{row: w.idx, col: '0, cov: '0, mean: w.t_mean, last: 1'b1, st: w.t_st};
            pending_entries.push_back(e);
        end
    endtask

    // Offer one word, hold until accepted; gap drawn up front unless in a burst.
    task automatic send_word(input t_stim_row w, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, w.cnt, w.idx, w.value};
        s_axis_tlast <= w.last;
        forever begin
            @(negedge i_clk);
            if (s_axis_tready) break;
        end
        @(posedge i_clk);
        predict_update(w);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return VAL_W'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial begin
        t_stim_row w;
        int ndim;
        int sent;
        logic [CNT_W-1:0] running;
        bit burst;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        foreach (mean_mdl[i]) begin
            mean_mdl[i] = 0;
            delta_mdl[i] = 0;
        end
        foreach (cov_mdl[i]) cov_mdl[i] = 0;

        // value, index, count, last, typed, typed mean, typed status
        dir_tab.push_back('{32'h1234_5678, 3'd3, 32'd0, 1'b0, 1'b1, 32'h0, ST_ZERO});
        dir_tab.push_back('{32'h8000_0000, 3'd0, 32'd1, 1'b0, 1'b1, 32'h8000_0000, ST_OK});
        dir_tab.push_back('{32'h7FFF_FFFF, 3'd1, 32'd1, 1'b0, 1'b0, 32'h0, ST_OK});
        dir_tab.push_back('{32'h0000_0000, 3'd2, 32'd1, 1'b0, 1'b0, 32'h0, ST_OK});
        dir_tab.push_back('{32'h0000_0001, 3'd3, 32'd1, 1'b0, 1'b0, 32'h0, ST_OK});
        dir_tab.push_back('{32'hFFFF_FFFF, 3'd4, 32'd1, 1'b0, 1'b0, 32'h0, ST_OK});
        dir_tab.push_back('{32'h8000_0000, 3'd5, 32'd1, 1'b0, 1'b0, 32'h0, ST_OK});
        dir_tab.push_back('{32'h0001_0000, 3'd6, 32'd1, 1'b0, 1'b0, 32'h0, ST_OK});
        dir_tab.push_back('{32'h7FFF_FFFF, 3'd7, 32'd1, 1'b1, 1'b0, 32'h0, ST_OK});
        dir_tab.push_back('{32'h7FFF_FFFF, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, ST_OK});
        dir_tab.push_back('{32'h8000_0000, 3'd7, 32'd2, 1'b1, 1'b0, 32'h0, ST_OK});
        dir_tab.push_back('{32'h7FFF_FFFF, 3'd7, 32'd0, 1'b1, 1'b1, 32'h0, ST_ZERO});
        dir_tab.push_back('{32'h7FFF_FFFF, 3'd0, 32'd1, 1'b0, 1'b1, 32'h7FFF_FFFF, ST_OK});
        dir_tab.push_back('{32'h8000_0000, 3'd1, 32'd3, 1'b0, 1'b0, 32'h0, ST_OK});
        dir_tab.push_back('{32'h1234_5678, 3'd3, 32'd3, 1'b0, 1'b0, 32'h0, ST_OK});
        dir_tab.push_back('{32'h7FFF_FFFF, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, ST_OK});
        dir_tab.push_back('{32'h0000_0000, 3'd5, 32'd0, 1'b0, 1'b1, 32'h0, ST_ZERO});
        dir_tab.push_back('{32'hFFFF_0000, 3'd2, 32'd5, 1'b1, 1'b0, 32'h0, ST_OK});
        dir_tab.push_back('{32'h0000_0000, 3'd0, 32'd2, 1'b0, 1'b0, 32'h0, ST_OK});
        dir_tab.push_back('{32'hFFFF_FFFF, 3'd6, 32'h8000_0000, 1'b0, 1'b0, 32'h0, ST_OK});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // rows 2..9 write every delta entry in order before any random index is used
        foreach (dir_tab[r]) send_word(dir_tab[r], 1'b0);

        sent = 0;
        running = 32'd2;
        while (sent < RAND_ITEMS) begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) begin
                // well-formed sample vector, components in order
                ndim = $urandom_range(1, N_DIMS);
                case ($urandom_range(0, 7))
                    0: running = $urandom;
                    1: running = 32'd1;
                    default: running = running + 1;
                endcase
                for (int i = 0; i < ndim; i++) begin
                    w = '{pick_value(), IDX_W'(i), running, i == ndim - 1, 1'b0, '0, ST_OK};
                    send_word(w, burst);
                    sent++;
                end
            end else begin
                // stray word: any index, odd counts, zero count now and then
                w.value = pick_value();
                w.idx = IDX_W'($urandom_range(0, N_DIMS - 1));
                case ($urandom_range(0, 3))
                    0: w.cnt = '0;
                    1: w.cnt = $urandom;
                    default: w.cnt = $urandom_range(1, 40);
                endcase
                w.last = $urandom_range(0, 1);
                w.typed = 1'b0;
                send_word(w, burst);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;
        feed_done = 1;
    end

    // result side: random tready gaps, one long hold to back the block up
    initial begin
        t_cov_entry got, want;
        int gap;
        int nwords;
        m_axis_tready = 1'b0;
        nwords = 0;
        @(posedge i_clk iff i_rst_n);
        m_axis_tready <= 1'b1;
        forever begin
            forever begin
                @(negedge i_clk);
                if (m_axis_tvalid) break;
            end
            got.row = m_axis_tdata[2:0];
            got.col = m_axis_tdata[5:3];
            got.cov = m_axis_tdata[53:6];
            got.mean = m_axis_tdata[85:54];
            got.last = m_axis_tlast;
            got.st = m_axis_tuser;
            @(posedge i_clk);
            nwords++;
            if (pending_entries.size() == 0) begin
                errors++;
                $display("%0t unexpected word: expected none, actual %h", $time, got);
            end else begin
                want = pending_entries.pop_front();
                if (got.row !== want.row || got.col !== want.col || got.cov !== want.cov ||
                    got.mean !== want.mean || got.last !== want.last || got.st !== want.st) begin
                    errors++;
                    $display("%0t mismatch: expected row %0d col %0d cov %h mean %h last %b st %0d",
                             $time, want.row, want.col, want.cov, want.mean, want.last, want.st);
                    $display("%0t           actual row %0d col %0d cov %h mean %h last %b st %0d",
                             $time, got.row, got.col, got.cov, got.mean, got.last, got.st);
                end
            end
            if (nwords == HOLD_AT_WORD) begin
                gap = HOLD_CYCLES;
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // end of run
    initial begin
        wait (feed_done);
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
